@@ hdl/adc2w_pkg.sv @@
// shared types and constants for the two-wire converter serial master
package adc2w_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDCONV,
        ST_RDCFG,
        ST_WRCFG,
        ST_WAIT1,
        ST_IWRITE,
        ST_WAIT2,
        ST_IREAD,
        ST_IFIN
    } adc2w_state_t;

    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_READ_CONV   = 3'd1,
        CMD_READ_CFG    = 3'd2,
        CMD_WRITE_CFG   = 3'd3,
        CMD_POWER_DOWN  = 3'd4,
        CMD_RESTART     = 3'd5,
        CMD_INIT_VERIFY = 3'd6
    } adc2w_cmd_t;

    localparam logic CFG_HALF_PERIOD   = 1'b0;
    localparam logic CFG_READY_TIMEOUT = 1'b1;

    localparam logic [7:0]  HALF_PERIOD_RESET   = 8'd10;
    localparam logic [17:0] READY_TIMEOUT_RESET = 18'd150000;

    localparam logic [6:0] CMD_READ_BYTE  = 7'h56;
    localparam logic [6:0] CMD_WRITE_BYTE = 7'h65;

    localparam logic [5:0] CONV_LAST_PULSE = 6'd27;
    localparam logic [5:0] CFG_LAST_PULSE  = 6'd46;
    localparam logic [5:0] CODE_LAST_PULSE = 6'd24;
    localparam logic [5:0] CMD_FIRST_PULSE = 6'd30;
    localparam logic [5:0] CMD_LAST_PULSE  = 6'd36;
    localparam logic [5:0] TURN_PULSE      = 6'd37;
    localparam logic [5:0] BYTE_FIRST_PULSE = 6'd38;
    localparam logic [5:0] BYTE_LAST_PULSE  = 6'd45;

    // 10000 / 13108 reduces to 2500 / 3277
    localparam int unsigned SCALE_MUL   = 2500;
    localparam int unsigned SCALE_DIV   = 3277;
    localparam int unsigned RECIP_SHIFT = 41;
    localparam logic [63:0] SCALE_RECIP_64 = (64'd1 << RECIP_SHIFT) / 64'(SCALE_DIV);
    localparam logic [29:0] SCALE_RECIP = SCALE_RECIP_64[29:0];

endpackage

@@ hdl/adc2w_scale.sv @@
// four-stage pipeline: code >>> 6, times 10000 / 13108 truncated toward zero
module adc2w_scale
    import adc2w_pkg::*;
(
    input  logic               clk,
    input  logic        [23:0] code,
    output logic signed [17:0] scaled
);

    logic        [17:0] mag;
    logic        [28:0] n1_reg;
    logic               sign1_reg;
    logic        [28:0] n2_reg;
    logic        [16:0] qe2_reg;
    logic               sign2_reg;
    logic        [58:0] recip_prod;
    logic        [28:0] back_prod;
    logic        [28:0] rem;
    logic        [16:0] q3_reg;
    logic               sign3_reg;
    logic signed [17:0] scaled_reg;

    assign mag = code[23] ? 18'(-code[23:6]) : code[23:6];

    // reciprocal estimate is low by at most one, fixed in the third stage
    assign recip_prod = 59'(n1_reg * 59'(SCALE_RECIP));
    assign back_prod  = 29'(qe2_reg * 29'(SCALE_DIV));
    assign rem        = n2_reg - back_prod;

    always_ff @(posedge clk)
    begin
        n1_reg     <= 29'(mag * 30'(SCALE_MUL));
        sign1_reg  <= code[23];
        n2_reg     <= n1_reg;
        sign2_reg  <= sign1_reg;
        qe2_reg    <= 17'(recip_prod >> RECIP_SHIFT);
        q3_reg     <= (rem >= 29'(SCALE_DIV)) ? qe2_reg + 17'd1 : qe2_reg;
        sign3_reg  <= sign2_reg;
        scaled_reg <= sign3_reg ? -$signed({1'b0, q3_reg}) : $signed({1'b0, q3_reg});
    end

    assign scaled = scaled_reg;

endmodule

@@ hdl/adc_two_wire_serial_master_core.sv @@
// Serial master for a 24-bit sigma-delta converter with a shared data pin.
// Each input transfer is one pin tick and yields one result transfer; a tick is
// taken every cycle while the result register is empty or being drained, so the
// block runs at one tick per cycle under that condition, and each tick's result
// is registered. The scaled conversion comes from a four-stage pipeline that
// follows the captured code; the code is settled at least six ticks before a run
// ends, so the scaled value is always current when it is latched. Configuration
// writes take effect at once and should be made while no command is running.
module adc_two_wire_serial_master_core
    import adc2w_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic               cfg_index,
    input  logic        [17:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic        [2:0]  command,
    input  logic        [7:0]  config_value,
    input  logic               data_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               serial_clock,
    output logic               data_out,
    output logic               data_drive,
    output logic               busy_res,
    output logic               done_res,
    output logic               timed_out,
    output logic               mismatch,
    output logic signed [23:0] raw_code,
    output logic signed [17:0] conversion,
    output logic        [7:0]  config_readback
);

    logic         [7:0]  half_period_reg;
    logic         [17:0] ready_timeout_reg;
    logic         [7:0]  hp;
    logic         [17:0] rt;

    adc2w_state_t        state_reg, state_next, run_state;
    logic         [5:0]  pulse_reg, pulse_next;
    logic         [7:0]  phase_reg, phase_next;
    logic         [17:0] wait_reg, wait_next;
    logic         [23:0] sample_reg, sample_next;
    logic         [7:0]  byte_reg, byte_next;
    logic         [7:0]  held_reg, held_next;
    logic                level_reg, level_next;
    logic         [23:0] raw_reg, raw_next;
    logic signed  [17:0] conv_reg, conv_next;
    logic         [7:0]  readback_reg, readback_next;

    logic                sclk_reg, dout_reg, drive_reg, done_reg, to_reg, mm_reg;
    logic                out_valid_reg;
    logic                sclk, dout, drive, done, to, mm, fresh;
    logic                is_conv, is_rdcfg, is_write;
    logic         [6:0]  cmd_byte;
    logic         [5:0]  last_pulse;
    logic         [5:0]  cmd_bit, val_bit;
    logic signed  [17:0] scaled;
    logic                in_fire;

    adc2w_scale u_scale (
        .clk    (clk),
        .code   (sample_reg),
        .scaled (scaled)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign hp = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign rt = (ready_timeout_reg == 18'd0) ? 18'd1 : ready_timeout_reg;

    always_comb
    begin
        state_next    = state_reg;
        pulse_next    = pulse_reg;
        phase_next    = phase_reg;
        wait_next     = wait_reg;
        sample_next   = sample_reg;
        byte_next     = byte_reg;
        held_next     = held_reg;
        level_next    = level_reg;
        raw_next      = raw_reg;
        conv_next     = conv_reg;
        readback_next = readback_reg;
        dout  = 1'b0;
        drive = 1'b0;
        done  = 1'b0;
        to    = 1'b0;
        mm    = 1'b0;
        fresh = 1'b0;

        if (state_reg == ST_IDLE)
        begin
            case (adc2w_cmd_t'(command))
                CMD_READ_CONV, CMD_READ_CFG, CMD_WRITE_CFG:
                begin
                    held_next   = config_value;
                    pulse_next  = 6'd1;
                    phase_next  = 8'd0;
                    level_next  = 1'b1;
                    sample_next = 24'd0;
                    byte_next   = 8'd0;
                    if (adc2w_cmd_t'(command) == CMD_READ_CONV)
                        state_next = ST_RDCONV;
                    else if (adc2w_cmd_t'(command) == CMD_READ_CFG)
                        state_next = ST_RDCFG;
                    else
                        state_next = ST_WRCFG;
                end
                CMD_POWER_DOWN:
                begin
                    level_next = 1'b1;
                    done       = 1'b1;
                end
                CMD_RESTART:
                begin
                    level_next = 1'b0;
                    done       = 1'b1;
                end
                CMD_INIT_VERIFY:
                begin
                    level_next = 1'b0;
                    held_next  = config_value;
                    wait_next  = 18'd0;
                    state_next = ST_WAIT1;
                    fresh      = 1'b1;
                end
                default: ;
            endcase
        end

        run_state  = state_next;
        sclk       = level_next;
        is_conv    = (run_state == ST_RDCONV);
        is_rdcfg   = (run_state == ST_RDCFG) || (run_state == ST_IREAD);
        is_write   = (run_state == ST_WRCFG) || (run_state == ST_IWRITE);
        cmd_byte   = is_write ? CMD_WRITE_BYTE : CMD_READ_BYTE;
        last_pulse = is_conv ? CONV_LAST_PULSE : CFG_LAST_PULSE;
        cmd_bit    = CMD_LAST_PULSE - pulse_next;
        val_bit    = BYTE_LAST_PULSE - pulse_next;

        case (run_state)
            ST_RDCONV, ST_RDCFG, ST_WRCFG, ST_IWRITE, ST_IREAD:
            begin
                if (!is_conv)
                begin
                    if (pulse_next >= CMD_FIRST_PULSE && pulse_next <= CMD_LAST_PULSE)
                    begin
                        drive = 1'b1;
                        dout  = cmd_byte[cmd_bit[2:0]];
                    end
                    else if (pulse_next == TURN_PULSE && is_write)
                    begin
                        drive = 1'b1;
                        dout  = cmd_byte[0];
                    end
                    else if (pulse_next >= BYTE_FIRST_PULSE &&
                             pulse_next <= BYTE_LAST_PULSE && is_write)
                    begin
                        drive = 1'b1;
                        dout  = held_next[val_bit[2:0]];
                    end
                end

                if ((9'(phase_next) + 9'd1) >= 9'(hp))
                begin
                    phase_next = 8'd0;
                    if (level_next)
                        level_next = 1'b0;
                    else
                    begin
                        // sample on the last tick of the low half
                        if (pulse_next >= 6'd1 && pulse_next <= CODE_LAST_PULSE)
                            sample_next = {sample_next[22:0], data_in};
                        if (is_rdcfg && pulse_next >= BYTE_FIRST_PULSE &&
                            pulse_next <= BYTE_LAST_PULSE)
                            byte_next = {byte_next[6:0], data_in};
                        if (pulse_next >= last_pulse)
                        begin
                            raw_next  = sample_next;
                            conv_next = scaled;
                            if (is_rdcfg)
                                readback_next = byte_next;
                            pulse_next = 6'd0;
                            if (run_state == ST_IWRITE)
                            begin
                                wait_next  = 18'd0;
                                state_next = ST_WAIT2;
                            end
                            else if (run_state == ST_IREAD)
                                state_next = ST_IFIN;
                            else
                            begin
                                state_next = ST_IDLE;
                                done       = 1'b1;
                            end
                        end
                        else
                        begin
                            pulse_next = pulse_next + 6'd1;
                            level_next = 1'b1;
                        end
                    end
                end
                else
                    phase_next = phase_next + 8'd1;
            end
            ST_WAIT1, ST_WAIT2:
            begin
                if (!fresh)
                begin
                    sclk = 1'b0;
                    if (!data_in)
                    begin
                        state_next  = (run_state == ST_WAIT1) ? ST_IWRITE : ST_IREAD;
                        pulse_next  = 6'd1;
                        phase_next  = 8'd0;
                        level_next  = 1'b1;
                        sample_next = 24'd0;
                        byte_next   = 8'd0;
                    end
                    else
                    begin
                        wait_next = wait_next + 18'd1;
                        if (wait_next >= rt)
                        begin
                            wait_next  = 18'd0;
                            state_next = ST_IDLE;
                            done       = 1'b1;
                            to         = 1'b1;
                        end
                    end
                end
            end
            ST_IFIN:
            begin
                level_next = 1'b1;
                sclk       = 1'b1;
                mm         = (readback_reg != held_next);
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HALF_PERIOD_RESET;
            ready_timeout_reg <= READY_TIMEOUT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD:   half_period_reg   <= cfg_data[7:0];
                CFG_READY_TIMEOUT: ready_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pulse_reg     <= 6'd0;
            phase_reg     <= 8'd0;
            wait_reg      <= 18'd0;
            sample_reg    <= 24'd0;
            byte_reg      <= 8'd0;
            held_reg      <= 8'd0;
            level_reg     <= 1'b0;
            raw_reg       <= 24'd0;
            conv_reg      <= 18'sd0;
            readback_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg    <= state_next;
                pulse_reg    <= pulse_next;
                phase_reg    <= phase_next;
                wait_reg     <= wait_next;
                sample_reg   <= sample_next;
                byte_reg     <= byte_next;
                held_reg     <= held_next;
                level_reg    <= level_next;
                raw_reg      <= raw_next;
                conv_reg     <= conv_next;
                readback_reg <= readback_next;
            end
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // pin levels and status flags of the tick, held with the result transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sclk_reg  <= sclk;
            dout_reg  <= dout;
            drive_reg <= drive;
            done_reg  <= done;
            to_reg    <= to;
            mm_reg    <= mm;
        end
    end

    assign out_valid       = out_valid_reg;
    assign serial_clock    = sclk_reg;
    assign data_out        = dout_reg;
    assign data_drive      = drive_reg;
    assign busy_res        = (state_reg != ST_IDLE);
    assign done_res        = done_reg;
    assign timed_out       = to_reg;
    assign mismatch        = mm_reg;
    assign raw_code        = raw_reg;
    assign conversion      = conv_reg;
    assign config_readback = readback_reg;

    a_dout_needs_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_out |-> data_drive)
        else $error("data driven high while pin released");

    a_outcome_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (timed_out || mismatch) |-> done_res)
        else $error("init outcome flag without done");

    a_drive_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && data_drive |-> busy_res)
        else $error("pin driven with no command running");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(state_reg) && $stable(pulse_reg))
        else $error("sequencer moved without a transfer");

    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDCONV || state_reg == ST_RDCFG || state_reg == ST_WRCFG ||
         state_reg == ST_IWRITE || state_reg == ST_IREAD)
        |-> (pulse_reg >= 6'd1 && pulse_reg <= CFG_LAST_PULSE))
        else $error("pulse index out of range during a run");

endmodule
